// ===== rtl/core/ctip_pkg.sv =====
// ctip_pkg: shared types and constants of the cubic table interpolator
// holds the input and output word structs, action codes and reset values
// no dependencies; imported by cubic_table_interpolator_top
package ctip_pkg;

    // default number of table entries
    localparam int TABLE_DEPTH_DEF = 256;

    // reset value of the grid-per-unit register (1.0 in Q16.16)
    localparam logic [31:0] GRID_PER_UNIT_RST = 32'h0001_0000;

    // action codes of an input word
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // ceil(2^33 / 3): floor(y * RECIP3 / 2^33) == floor(y / 3) for any 32-bit y
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    // input word
    typedef struct packed {
        logic               action;
        logic [7:0]         table_addr;
        logic signed [15:0] sample;
        logic signed [31:0] freq;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [15:0] value;
        logic               in_range;
        logic               clipped;
    } t_out_word;

endpackage

// ===== rtl/core/cubic_table_interpolator_top.sv =====
// cubic_table_interpolator_top: pipelined four-point cubic interpolation over a spectrum table
// depends on ctip_pkg for the word structs, action codes and constants
// the table is kept in four interleaved banks inside this module

// The block takes one word per cycle on each side unless the output stalls; an evaluate word
// passes every stage register to its output word; bubbles collapse, so input is still taken while
// a finished word waits at the output. A write word stores its sample into the table and
// gives no output word; an evaluate word gives exactly one. The table sits in four banks
// interleaved on the low two address bits, each with one read/write port, so the four
// neighboring entries of an evaluation are fetched in a single cycle. Writes are applied at
// the same stage where evaluations read, so words act on the table in arrival order. The
// table is not cleared by reset: every entry must be written before an evaluation uses it.
// The grid-per-unit register may only be written while no word is in flight.
module cubic_table_interpolator_top #(
    parameter int TABLE_DEPTH = ctip_pkg::TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ctip_pkg::t_in_word   i_in_data,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ctip_pkg::t_out_word  o_out_data
);

    import ctip_pkg::*;

    localparam int NS   = 10;
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int PW   = AW + 17;
    localparam int IW   = AW + 2;
    localparam int EW   = (AW > 8) ? AW : 8;
    localparam int ROWS = (TABLE_DEPTH + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int HALF = TABLE_DEPTH / 2;

    localparam logic [47:0] SPAN_LIM = 48'(TABLE_DEPTH) * 48'd32768;
    localparam logic [31:0] T_OFS    = 32'(TABLE_DEPTH) * 32'd32768;
    localparam logic [59:0] RND_W    = 60'd262144;
    localparam logic [59:0] RND_Y    = 60'd786432;
    localparam logic [52:0] RND_V    = 53'd536870912;

    // configuration register
    logic [31:0] r_gpu;

    // stage control
    logic [NS:1] r_vld;
    logic [NS:1] w_en;
    logic [NS:1] w_vin;

    // stage 1: product of frequency magnitude and grid_per_unit
    logic               r1_act;
    logic [7:0]         r1_addr;
    logic signed [15:0] r1_sample;
    logic               r1_neg;
    logic [63:0]        r1_prod;
    logic [31:0]        w1_fmag;
    logic [63:0]        n1_prod;

    // stage 2: signed grid position and span check
    logic               r2_act;
    logic [7:0]         r2_addr;
    logic signed [15:0] r2_sample;
    logic               r2_inr;
    logic signed [PW-1:0] r2_p;
    logic [47:0]        w2_pm;
    logic [PW-1:0]      w2_pt;
    logic signed [PW-1:0] n2_p;
    logic               n2_inr;

    // stage 3: cell index, base entry, offset and bank rows
    logic               r3_act;
    logic signed [15:0] r3_sample;
    logic               r3_ok;
    logic signed [19:0] r3_t;
    logic [1:0]         r3_brot;
    logic [RW-1:0]      r3_row [4];
    logic [3:0]         r3_we;
    logic signed [AW:0] w3_pf;
    logic signed [IW-1:0] w3_idx;
    logic [AW-1:0]      w3_iu;
    logic [AW-1:0]      w3_b;
    logic [31:0]        w3_t32;
    logic               w3_wok;
    logic [RW-1:0]      w3_wrow;
    logic [RW-1:0]      w3_erow [4];
    logic               n3_ok;
    logic [RW-1:0]      n3_row [4];
    logic [3:0]         n3_we;

    // stage 4: table read, offsets and pair products
    logic signed [15:0] r_mem [4][ROWS];
    logic signed [15:0] r4_rd [4];
    logic               r4_ok;
    logic [1:0]         r4_brot;
    logic signed [19:0] r4_d [4];
    logic signed [39:0] r4_p23;
    logic signed [39:0] r4_p01;
    logic signed [19:0] w4_d [4];

    // stage 5: triple products and samples in entry order
    logic               r5_ok;
    logic signed [59:0] r5_x [4];
    logic signed [15:0] r5_smp [4];

    // stage 6: rounded weights, thirds still pending for the outer two
    logic               r6_ok;
    logic signed [15:0] r6_smp [4];
    logic signed [34:0] r6_w1;
    logic signed [34:0] r6_w2;
    logic [31:0]        r6_y0;
    logic [31:0]        r6_y3;
    logic               r6_n0;
    logic               r6_n3;
    logic [59:0]        w6_m [4];
    logic [34:0]        w6_q1;
    logic [34:0]        w6_q2;

    // stage 7: all four weights
    logic               r7_ok;
    logic signed [15:0] r7_smp [4];
    logic signed [34:0] r7_w [4];
    logic [63:0]        w7_pr0;
    logic [63:0]        w7_pr3;

    // stage 8: weighted samples
    logic               r8_ok;
    logic signed [50:0] r8_m [4];

    // stage 9: sum
    logic               r9_ok;
    logic signed [52:0] r9_acc;

    // stage 10: output word
    t_out_word          r_out;
    logic [52:0]        w10_mag;
    logic [22:0]        w10_q;
    t_out_word          n_out;

    // configuration register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpu <= GRID_PER_UNIT_RST;
        end else if (i_cfg_we) begin
            r_gpu <= i_cfg_wdata;
        end
    end

    // stage enables: a stage loads when it is empty or its successor loads
    always_comb begin
        w_en[NS] = !r_vld[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    // valid entering each stage; write words end at the table stage
    always_comb begin
        w_vin[1] = i_in_valid;
        for (int k = 2; k <= NS; k++) begin
            w_vin[k] = r_vld[k - 1];
        end
        w_vin[4] = r_vld[3] && (r3_act == ACT_EVAL);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage 1 math: magnitude times grid-per-unit
    always_comb begin
        w1_fmag = i_in_data.freq[31] ? (32'd0 - $unsigned(i_in_data.freq))
                                     : $unsigned(i_in_data.freq);
        n1_prod = w1_fmag * r_gpu;
    end

    // stage 2 math: floor to Q16.16 position, span check, apply sign
    always_comb begin
        w2_pm  = r1_neg ? 48'((r1_prod + 64'h0000_0000_0000_FFFF) >> 16)
                        : 48'(r1_prod >> 16);
        n2_inr = (w2_pm <= SPAN_LIM);
        w2_pt  = w2_pm[PW-1:0];
        n2_p   = r1_neg ? signed'(PW'(0) - w2_pt) : signed'(w2_pt);
    end

    // stage 3 math: index, base entry with edge shift, offset, bank rows
    always_comb begin
        w3_pf  = r2_p[PW-1:16];
        w3_idx = IW'(w3_pf) + IW'(HALF) - IW'(1);
        n3_ok  = r2_inr && !w3_idx[IW-1] && (w3_idx < IW'(TABLE_DEPTH));
        w3_iu  = w3_idx[AW-1:0];
        if (w3_iu == '0) begin
            w3_b = '0;
        end else if (w3_iu == AW'(TABLE_DEPTH - 1) || w3_iu == AW'(TABLE_DEPTH - 2)) begin
            w3_b = AW'(TABLE_DEPTH - 4);
        end else begin
            w3_b = w3_iu - AW'(1);
        end
        w3_t32  = 32'(r2_p) + T_OFS - ((32'(w3_b) + 32'd1) << 16);
        w3_wok  = (32'(r2_addr) < 32'(TABLE_DEPTH));
        w3_wrow = RW'(EW'(r2_addr) >> 2);
        for (int k = 0; k < 4; k++) begin
            w3_erow[k] = RW'((w3_b >> 2) + AW'(2'(k) < w3_b[1:0]));
            n3_row[k]  = (r2_act == ACT_WRITE) ? w3_wrow : w3_erow[k];
            n3_we[k]   = (r2_act == ACT_WRITE) && w3_wok && (r2_addr[1:0] == 2'(k));
        end
    end

    // stage 4 math: offsets from the four nodes
    always_comb begin
        w4_d[0] = r3_t;
        w4_d[1] = r3_t - 20'sd65536;
        w4_d[2] = r3_t - 20'sd131072;
        w4_d[3] = r3_t - 20'sd196608;
    end

    // table banks: per bank and cycle, one read and at most one write of the same row
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int k = 0; k < 4; k++) begin
                if (r_vld[3] && r3_we[k]) begin
                    r_mem[k][r3_row[k]] <= r3_sample;
                end
                r4_rd[k] <= r_mem[k][r3_row[k]];
            end
        end
    end

    // stage 6 math: rounding of the triple products
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w6_m[k] = r5_x[k][59] ? (60'd0 - $unsigned(r5_x[k])) : $unsigned(r5_x[k]);
        end
        w6_q1 = 35'((w6_m[1] + RND_W) >> 19);
        w6_q2 = 35'((w6_m[2] + RND_W) >> 19);
    end

    // stage 7 math: divide the outer two by three
    always_comb begin
        w7_pr0 = r6_y0 * RECIP3;
        w7_pr3 = r6_y3 * RECIP3;
    end

    // stage 10 math: round off Q30, saturate, zero when out of range
    always_comb begin
        w10_mag = r9_acc[52] ? (53'd0 - $unsigned(r9_acc)) : $unsigned(r9_acc);
        w10_q   = 23'((w10_mag + RND_V) >> 30);
        n_out   = '0;
        if (r9_ok) begin
            n_out.in_range = 1'b1;
            if (!r9_acc[52] && w10_q > 23'd32767) begin
                n_out.value   = 16'sh7FFF;
                n_out.clipped = 1'b1;
            end else if (r9_acc[52] && w10_q > 23'd32768) begin
                n_out.value   = 16'sh8000;
                n_out.clipped = 1'b1;
            end else if (r9_acc[52]) begin
                n_out.value = signed'(16'd0 - w10_q[15:0]);
            end else begin
                n_out.value = signed'(w10_q[15:0]);
            end
        end
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_act    <= i_in_data.action;
            r1_addr   <= i_in_data.table_addr;
            r1_sample <= i_in_data.sample;
            r1_neg    <= i_in_data.freq[31];
            r1_prod   <= n1_prod;
        end
        if (w_en[2]) begin
            r2_act    <= r1_act;
            r2_addr   <= r1_addr;
            r2_sample <= r1_sample;
            r2_inr    <= n2_inr;
            r2_p      <= n2_p;
        end
        if (w_en[3]) begin
            r3_act    <= r2_act;
            r3_sample <= r2_sample;
            r3_ok     <= n3_ok;
            r3_t      <= w3_t32[19:0];
            r3_brot   <= w3_b[1:0];
            r3_row    <= n3_row;
            r3_we     <= n3_we;
        end
        if (w_en[4]) begin
            r4_ok   <= r3_ok;
            r4_brot <= r3_brot;
            r4_d    <= w4_d;
            r4_p23  <= w4_d[2] * w4_d[3];
            r4_p01  <= w4_d[0] * w4_d[1];
        end
        if (w_en[5]) begin
            r5_ok   <= r4_ok;
            r5_x[0] <= r4_d[1] * r4_p23;
            r5_x[1] <= r4_d[0] * r4_p23;
            r5_x[2] <= r4_d[3] * r4_p01;
            r5_x[3] <= r4_d[2] * r4_p01;
            for (int k = 0; k < 4; k++) begin
                r5_smp[k] <= r4_rd[2'(r4_brot + 2'(k))];
            end
        end
        if (w_en[6]) begin
            r6_ok  <= r5_ok;
            r6_smp <= r5_smp;
            r6_w1  <= r5_x[1][59] ? signed'(35'd0 - w6_q1) : signed'(w6_q1);
            r6_w2  <= r5_x[2][59] ? signed'(w6_q2) : signed'(35'd0 - w6_q2);
            r6_y0  <= 32'((w6_m[0] + RND_Y) >> 19);
            r6_y3  <= 32'((w6_m[3] + RND_Y) >> 19);
            r6_n0  <= !r5_x[0][59];
            r6_n3  <= r5_x[3][59];
        end
        if (w_en[7]) begin
            r7_ok   <= r6_ok;
            r7_smp  <= r6_smp;
            r7_w[0] <= r6_n0 ? signed'(35'd0 - 35'(w7_pr0[63:33])) : signed'(35'(w7_pr0[63:33]));
            r7_w[1] <= r6_w1;
            r7_w[2] <= r6_w2;
            r7_w[3] <= r6_n3 ? signed'(35'd0 - 35'(w7_pr3[63:33])) : signed'(35'(w7_pr3[63:33]));
        end
        if (w_en[8]) begin
            r8_ok <= r7_ok;
            for (int k = 0; k < 4; k++) begin
                r8_m[k] <= r7_w[k] * r7_smp[k];
            end
        end
        if (w_en[9]) begin
            r9_ok  <= r8_ok;
            r9_acc <= 53'(r8_m[0]) + 53'(r8_m[1]) + 53'(r8_m[2]) + 53'(r8_m[3]);
        end
        if (w_en[10]) begin
            r_out <= n_out;
        end
    end

    // ports
    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NS];
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // input back-pressure only comes from a stalled output word
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // an accepted word always occupies the first stage
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted word lost at first stage");

    // an out-of-range word carries neither a value nor a clip flag
    a_out_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.in_range) |->
            (o_out_data.value == 16'sd0 && !o_out_data.clipped))
        else $error("out-of-range word not zeroed");

    // a write word never reaches the stages past the table
    a_write_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en[4] && r_vld[3] && r3_act == ACT_WRITE) |=> !r_vld[4])
        else $error("write word passed the table stage");
`endif

endmodule

// ===== test/tb_cubic_table_interpolator_top.sv =====
// tb_cubic_table_interpolator_top: self-checking bench for the cubic table interpolator
// drives table writes and evaluations through valid/ready, checks each output word against an in-bench
// interpolation predictor or a directed expected word; depends on ctip_pkg and cubic_table_interpolator_top
`timescale 1ns / 1ps

module tb_cubic_table_interpolator_top;
    import ctip_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 45;
    localparam int NUM_PHASES     = 7;

    // directed stimulus row
    typedef struct {
        t_in_word  word;
        bit        has_exp;
        t_out_word exp;
    } t_stim_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    t_out_word   out_word;

    // predictor state
    logic signed [15:0] table_model [DEPTH];
    logic [31:0]        grid_model = GRID_PER_UNIT_RST;
    t_out_word          expected_q [$];
    t_stim_row          directed_rows [$];

    int burst_left    = 1;
    int words_sent    = 0;
    int evals_checked = 0;
    int clipped_seen  = 0;
    int outside_seen  = 0;
    int mismatches    = 0;
    t_out_word got_exp;

    cubic_table_interpolator_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // round num/den to nearest, ties away from zero
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // four-point lagrange value at the grid position of freq
    function automatic t_out_word predict_interp(logic [31:0] freq);
        t_out_word       r;
        longint unsigned fmag;
        longint unsigned prod;
        longint          span;
        longint          p;
        longint          idx;
        longint          b;
        longint          t;
        longint          d0, d1, d2, d3;
        longint          w [4];
        longint          acc;
        longint          v;
        longint unsigned wden;
        r    = '0;
        span = longint'(DEPTH) * 65536;
        wden = 6 * (longint'(1) << 18);
        fmag = freq[31] ? (64'h1_0000_0000 - {32'h0, freq}) : {32'h0, freq};
        prod = fmag * {32'h0, grid_model};
        if (freq[31])
            p = -longint'((prod + 64'hFFFF) >> 16);
        else
            p = longint'(prod >> 16);
        // outside the table span
        if (2 * p < -span || 2 * p > span)
            return r;
        idx = ((p + span) >>> 16) - DEPTH + DEPTH / 2 - 1;
        if (idx < 0 || idx >= DEPTH)
            return r;
        // pick the first of four neighbors, shifted inward at the edges
        if (idx < 1)
            b = idx;
        else if (idx == DEPTH - 1)
            b = idx - 3;
        else if (idx == DEPTH - 2)
            b = idx - 2;
        else
            b = idx - 1;
        t  = p + longint'(DEPTH) * 32768 - (b + 1) * 65536;
        d0 = t;
        d1 = t - 65536;
        d2 = t - 2 * 65536;
        d3 = t - 3 * 65536;
        w[0] = round_div(-(d1 * d2 * d3), wden);
        w[1] = round_div(3 * (d0 * d2 * d3), wden);
        w[2] = round_div(-3 * (d0 * d1 * d3), wden);
        w[3] = round_div(d0 * d1 * d2, wden);
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += w[k] * longint'(table_model[b + k]);
        v = round_div(acc, longint'(1) << 30);
        // saturate to sample width
        if (v > 32767) begin
            v = 32767;
            r.clipped = 1'b1;
        end else if (v < -32768) begin
            v = -32768;
            r.clipped = 1'b1;
        end
        r.value    = v[15:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    // hold the input side idle
    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // send one word, update the predictor on acceptance, then pace the bursts
    task automatic send_word(t_in_word w, bit has_exp, t_out_word exp);
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (w.action == ACT_WRITE) begin
            if (w.table_addr < DEPTH)
                table_model[w.table_addr] = w.sample;
        end else begin
            expected_q.insert(expected_q.size(), has_exp ? exp : predict_interp(w.freq));
        end
        // bursts of random length, gaps between them
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 25);
            idle_cycles($urandom_range(0, 8));
        end
    endtask

    // stop sending until every expected word is back and the pipeline has emptied
    task automatic drain_pipeline();
        idle_cycles(1);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        grid_model = v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_write(int addr, logic [15:0] sample);
        t_stim_row row;
        row.word            = '0;
        row.word.action     = ACT_WRITE;
        row.word.table_addr = addr[7:0];
        row.word.sample     = sample;
        row.has_exp         = 1'b0;
        row.exp             = '0;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic add_eval(logic [31:0] freq, bit has_exp, logic [15:0] value, logic in_range,
                            logic clipped);
        t_stim_row row;
        row.word          = '0;
        row.word.action   = ACT_EVAL;
        row.word.freq     = freq;
        row.has_exp       = has_exp;
        row.exp.value     = value;
        row.exp.in_range  = in_range;
        row.exp.clipped   = clipped;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // receiver stall pattern: modes of random length
    int rx_mode     = 0;
    int rx_left     = 0;
    int rx_cnt      = 0;
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_cnt++;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) < 7);
            2: out_ready <= (rx_cnt % 4 == 0);
            default: out_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // output checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected output word, actual value %0d in_range %0b clipped %0b",
                         $time, out_word.value, out_word.in_range, out_word.clipped);
                mismatches++;
            end else begin
                got_exp = expected_q.pop_front();
                evals_checked++;
                if (!got_exp.in_range)
                    outside_seen++;
                if (got_exp.clipped)
                    clipped_seen++;
                if (out_word.value !== got_exp.value) begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, got_exp.value, out_word.value);
                    mismatches++;
                end
                if (out_word.in_range !== got_exp.in_range) begin
                    $display("%0t: in_range mismatch, expected %0b, actual %0b",
                             $time, got_exp.in_range, out_word.in_range);
                    mismatches++;
                end
                if (out_word.clipped !== got_exp.clipped) begin
                    $display("%0t: clipped mismatch, expected %0b, actual %0b",
                             $time, got_exp.clipped, out_word.clipped);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any accepted word
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        t_in_word    w;
        longint      pos;
        longint      f;
        int          sel;
        logic [31:0] grid_set [NUM_PHASES];

        grid_set[0] = 32'h0000_0000;
        grid_set[1] = 32'hFFFF_FFFF;
        grid_set[2] = 32'h0000_0001;
        grid_set[3] = GRID_PER_UNIT_RST;
        grid_set[4] = $urandom_range(32'h0000_4000, 32'h0004_0000);
        grid_set[5] = $urandom;
        grid_set[6] = 32'h0002_0000;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry before any evaluation reads it
        for (int i = 0; i < DEPTH; i++) begin
            w            = '0;
            w.action     = ACT_WRITE;
            w.table_addr = i[7:0];
            w.sample     = 16'($urandom);
            send_word(w, 1'b0, '0);
        end

        // directed rows at the reset grid step, position equals frequency
        add_write(127, 16'sh7FFF);
        add_eval(32'h0000_0000, 1'b1, 16'sh7FFF, 1'b1, 1'b0);
        add_write(127, 16'sh8000);
        add_eval(32'h0000_0000, 1'b1, 16'sh8000, 1'b1, 1'b0);
        add_write(255, 16'sd1234);
        add_eval(32'h0080_0000, 1'b1, 16'sd1234, 1'b1, 1'b0);    // exactly the upper edge
        add_eval(32'h0080_0001, 1'b1, 16'sd0, 1'b0, 1'b0);       // just past the upper edge
        add_eval(32'hFF80_0000, 1'b1, 16'sd0, 1'b0, 1'b0);       // exactly the lower edge
        add_eval(32'hFF80_0001, 1'b0, '0, 1'b0, 1'b0);           // inside the lower edge cell
        add_write(0, 16'sh8000);
        add_eval(32'hFF81_0000, 1'b1, 16'sh8000, 1'b1, 1'b0);    // first entry, lower shift
        add_eval(32'h7FFF_FFFF, 1'b1, 16'sd0, 1'b0, 1'b0);
        add_eval(32'h8000_0000, 1'b1, 16'sd0, 1'b0, 1'b0);
        // alternating extremes overshoot between two samples
        add_write(120, 16'sh8000);
        add_write(121, 16'sh7FFF);
        add_write(122, 16'sh7FFF);
        add_write(123, 16'sh8000);
        add_eval(32'hFFFA_8000, 1'b0, '0, 1'b0, 1'b0);
        add_write(120, 16'sh7FFF);
        add_write(121, 16'sh8000);
        add_write(122, 16'sh8000);
        add_write(123, 16'sh7FFF);
        add_eval(32'hFFFA_8000, 1'b0, '0, 1'b0, 1'b0);
        add_eval(32'h0000_8000, 1'b0, '0, 1'b0, 1'b0);
        add_eval(32'h007F_C000, 1'b0, '0, 1'b0, 1'b0);           // upper edge cells
        add_eval(32'hFFFE_DCBB, 1'b0, '0, 1'b0, 1'b0);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].has_exp, directed_rows[i].exp);

        // random phases, one grid setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipeline();
            write_grid(grid_set[ph]);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                w   = '0;
                sel = $urandom_range(0, 99);
                if (sel < 25) begin
                    w.action     = ACT_WRITE;
                    w.table_addr = 8'($urandom);
                    w.sample     = 16'($urandom);
                    w.freq       = $urandom;
                end else begin
                    w.action     = ACT_EVAL;
                    w.table_addr = 8'($urandom);
                    w.sample     = 16'($urandom);
                    // target a grid position, then map it back to a frequency
                    if (sel < 35)
                        pos = longint'($urandom_range(0, 1)) * 256 * 65536 - 128 * 65536
                              + longint'($urandom_range(0, 4)) - 2;
                    else if (sel < 45)
                        pos = (longint'($urandom_range(0, 256)) - 128) * 65536;
                    else
                        pos = longint'($urandom_range(0, 258 * 65536)) - 129 * 65536;
                    if (sel >= 85 || grid_model == 0) begin
                        w.freq = $urandom;
                    end else begin
                        f = (pos <<< 16) / longint'(grid_model);
                        if (f > 64'sd2147483647)
                            f = 64'sd2147483647;
                        else if (f < -64'sd2147483648)
                            f = -64'sd2147483648;
                        w.freq = f[31:0];
                    end
                end
                send_word(w, 1'b0, '0);
            end
        end

        drain_pipeline();
        $display("sent %0d words over %0d grid settings; checked %0d evaluations",
                 words_sent, NUM_PHASES + 1, evals_checked);
        $display("of those %0d fell outside the table and %0d saturated",
                 outside_seen, clipped_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
